// ----- hw/rtl/apoc_pkg.sv -----
// Package for the access point observation cache.
// Holds the transfer payload structs, the status codes and cell data types.
// No dependencies.
package apoc_pkg;

  localparam int unsigned KEY_W  = 48;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned SEC_W  = 8;
  localparam int unsigned CNT_W  = 32;

  localparam logic       CMD_MERGE = 1'b0;
  localparam logic       CMD_FIND  = 1'b1;

  localparam logic [2:0] ST_SKIPPED   = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_CHANGED   = 3'd2;
  localparam logic [2:0] ST_UNCHANGED = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_NOTFOUND  = 3'd5;

  typedef struct packed {
    logic              command;
    logic [KEY_W-1:0]  bssid_key;
    logic              frame_complete;
    logic [LEN_W-1:0]  ssid_length;
    logic [WORD_W-1:0] ssid_bytes_0_7;
    logic [WORD_W-1:0] ssid_bytes_8_15;
    logic [WORD_W-1:0] ssid_bytes_16_23;
    logic [WORD_W-1:0] ssid_bytes_24_31;
    logic [CH_W-1:0]   beacon_chan;
    logic [SEC_W-1:0]  security_class;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [4:0]        entries_occupied;
    logic [CNT_W-1:0]  insert_count;
    logic [CNT_W-1:0]  update_count;
    logic [CNT_W-1:0]  eviction_count;
    logic [LEN_W-1:0]  entry_ssid_length;
    logic [WORD_W-1:0] entry_ssid_0_7;
    logic [WORD_W-1:0] entry_ssid_8_15;
    logic [WORD_W-1:0] entry_ssid_16_23;
    logic [WORD_W-1:0] entry_ssid_24_31;
    logic [CH_W-1:0]   entry_channel;
    logic [SEC_W-1:0]  entry_security;
  } out_item_t;

  // Stored contents of one entry.
  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [4*WORD_W-1:0] name;
    logic [CH_W-1:0]     chan;
    logic [SEC_W-1:0]    sec;
  } entry_t;

  // Search token passed along the chain of cells.
  typedef struct packed {
    logic   hit;
    entry_t data;
  } probe_t;

  // Write command broadcast from the controller to every cell.
  typedef struct packed {
    logic   wr_hit;
    logic   wr_ins;
    entry_t data;
  } cell_wr_t;

  // Bytes of a name that the change test compares; a length above 32 counts as 32.
  function automatic logic [4*WORD_W-1:0] name_mask(input logic [LEN_W-1:0] n);
    logic [4*WORD_W-1:0] m;
    logic [LEN_W-1:0]    c;
    begin
      m = '0;
      c = (n > LEN_W'(32)) ? LEN_W'(32) : n;
      for (int b = 0; b < 32; b++) begin
        if (LEN_W'(b) < c) m[b*8 +: 8] = 8'hFF;
      end
      return m;
    end
  endfunction

endpackage

// ----- hw/rtl/apoc_cell.sv -----
// One cache entry of the access point observation cache.
// Holds key, valid bit and record, and passes the search token on.
// Depends on apoc_pkg.
module apoc_cell
  import apoc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             search,
  input  logic [KEY_W-1:0] key,
  input  probe_t           probe_in,
  output probe_t           probe_out,
  input  logic             sel_ins,
  input  cell_wr_t         wr,
  output logic             valid
);

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  entry_t           data_r;
  logic             mine_r, mine_nxt;
  logic             match;
  probe_t           probe_r, probe_nxt;

  assign match = valid_r && (key_r == key);
  assign valid = valid_r;
  assign probe_out = probe_r;
  assign mine_nxt = search ? (match && !probe_in.hit) : mine_r;

  // The first matching cell claims the token; later cells pass it on.
  always_comb begin
    probe_nxt = probe_r;
    if (search) begin
      if (match && !probe_in.hit) begin
        probe_nxt = '{hit: 1'b1, data: data_r};
      end else begin
        probe_nxt = probe_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mine_r  <= 1'b0;
      probe_r <= '0;
    end else begin
      mine_r  <= mine_nxt;
      probe_r <= probe_nxt;
      if (wr.wr_ins && sel_ins) valid_r <= 1'b1;
    end
  end

  // Record write on hit update or insert.
  always_ff @(posedge clk) begin
    if ((wr.wr_hit && mine_r) || (wr.wr_ins && sel_ins)) data_r <= wr.data;
    if (wr.wr_ins && sel_ins) key_r <= key;
  end

endmodule

// ----- hw/rtl/access_point_observation_cache.sv -----
// Top level of the access point observation cache.
// Instantiates the chain of apoc_cell entries and holds the command sequencer.
// Depends on apoc_pkg and apoc_cell.

// Each command runs from the start transfer to the out_valid strobe through the
// states S_WALK, S_WRITE and S_OUT: in S_WALK the search token walks the chain
// of entry cells, in S_WRITE the merge is resolved and the write data and status
// are registered, and in S_OUT the entry is written and the result registered.
// busy is high in these states; the result is shown for exactly one cycle and
// must be taken then, as the receiver cannot stall it. A new command can be
// accepted in the cycle that shows the result.
module access_point_observation_cache
  import apoc_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int unsigned PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned STEP_W = $clog2(ENTRIES + 2);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_WRITE = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  in_item_t          item_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  ins_r, upd_r, evc_r;
  logic [CNT_W-1:0]  ins_nxt, upd_nxt, evc_nxt;
  logic [2:0]        status_r;
  entry_t            found_r;
  logic              wr_hit_r, wr_hit_nxt;
  logic              wr_ins_r, wr_ins_nxt;
  entry_t            wr_data_r;
  cell_wr_t          wr_cmd;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  probe_t           chain [ENTRIES+1];
  logic [ENTRIES-1:0] valid_v;
  logic [ENTRIES-1:0] sel_ins;
  logic             search;
  logic [5:0]       occ;

  assign chain[0] = '0;
  assign search = (state_r == S_WALK);
  assign wr_cmd = '{wr_hit: wr_hit_r, wr_ins: wr_ins_r, data: wr_data_r};

  // Row of entry cells.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign sel_ins[g] = (ptr_r == PTR_W'(g));
    apoc_cell u_cell (
      .clk(clk), .rst_n(rst_n), .search(search), .key(item_r.bssid_key),
      .probe_in(chain[g]), .probe_out(chain[g+1]), .sel_ins(sel_ins[g]),
      .wr(wr_cmd), .valid(valid_v[g])
    );
  end

  always_comb begin
    occ = '0;
    for (int i = 0; i < ENTRIES; i++) occ = occ + 6'(valid_v[i]);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_WALK;
      S_WALK:  if (step_r == STEP_W'(ENTRIES)) state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // Merge resolution from the token that left the last cell.
  probe_t  fin;
  entry_t  merged;
  logic    changed;
  logic [4*WORD_W-1:0] in_name;
  assign fin = chain[ENTRIES];
  assign in_name = {item_r.ssid_bytes_24_31, item_r.ssid_bytes_16_23,
                    item_r.ssid_bytes_8_15, item_r.ssid_bytes_0_7};
  always_comb begin
    merged.len  = (item_r.ssid_length != '0) ? item_r.ssid_length : fin.data.len;
    merged.name = (item_r.ssid_length != '0) ? in_name : fin.data.name;
    merged.chan = (item_r.beacon_chan != '0) ? item_r.beacon_chan
                                             : fin.data.chan;
    merged.sec  = item_r.security_class;
    changed = (merged.len != fin.data.len) || (merged.chan != fin.data.chan) ||
              (merged.sec != fin.data.sec) ||
              ((item_r.ssid_length != '0) &&
               (((fin.data.name ^ in_name) & name_mask(merged.len)) != '0));
  end

  // Next values of the step counter, replace pointer, totals and strobes.
  always_comb begin
    step_nxt      = step_r;
    ptr_nxt       = ptr_r;
    ins_nxt       = ins_r;
    upd_nxt       = upd_r;
    evc_nxt       = evc_r;
    wr_hit_nxt    = 1'b0;
    wr_ins_nxt    = 1'b0;
    out_valid_nxt = (state_r == S_OUT);
    if (state_r == S_IDLE && start) step_nxt = '0;
    if (state_r == S_WALK) step_nxt = step_r + 1'b1;
    if (state_r == S_WRITE && item_r.command == CMD_MERGE &&
        item_r.frame_complete) begin
      if (fin.hit) begin
        wr_hit_nxt = 1'b1;
        if (changed) upd_nxt = upd_r + 1'b1;
      end else begin
        wr_ins_nxt = 1'b1;
        ins_nxt = ins_r + 1'b1;
        if (valid_v[ptr_r]) evc_nxt = evc_r + 1'b1;
      end
    end
    if (state_r == S_OUT && wr_ins_r)
      ptr_nxt = (ptr_r == PTR_W'(ENTRIES - 1)) ? '0 : ptr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      ptr_r       <= '0;
      ins_r       <= '0;
      upd_r       <= '0;
      evc_r       <= '0;
      wr_hit_r    <= 1'b0;
      wr_ins_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      ptr_r       <= ptr_nxt;
      ins_r       <= ins_nxt;
      upd_r       <= upd_nxt;
      evc_r       <= evc_nxt;
      wr_hit_r    <= wr_hit_nxt;
      wr_ins_r    <= wr_ins_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result fields; an insert that is being written counts toward occupancy.
  always_comb begin
    out_nxt = '0;
    out_nxt.status           = status_r;
    out_nxt.entries_occupied = occ[4:0] + 5'(wr_ins_r && !valid_v[ptr_r]);
    out_nxt.insert_count     = ins_r;
    out_nxt.update_count     = upd_r;
    out_nxt.eviction_count   = evc_r;
    if (status_r == ST_FOUND) begin
      out_nxt.entry_ssid_length = found_r.len;
      out_nxt.entry_ssid_0_7    = found_r.name[0*WORD_W +: WORD_W];
      out_nxt.entry_ssid_8_15   = found_r.name[1*WORD_W +: WORD_W];
      out_nxt.entry_ssid_16_23  = found_r.name[2*WORD_W +: WORD_W];
      out_nxt.entry_ssid_24_31  = found_r.name[3*WORD_W +: WORD_W];
      out_nxt.entry_channel     = found_r.chan;
      out_nxt.entry_security    = found_r.sec;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) item_r <= in_item;
    if (state_r == S_WRITE) begin
      found_r <= fin.data;
      if (item_r.command == CMD_FIND) begin
        wr_data_r <= fin.data;
        status_r  <= fin.hit ? ST_FOUND : ST_NOTFOUND;
      end else if (!item_r.frame_complete) begin
        wr_data_r <= merged;
        status_r  <= ST_SKIPPED;
      end else if (fin.hit) begin
        wr_data_r <= merged;
        status_r  <= changed ? ST_CHANGED : ST_UNCHANGED;
      end else begin
        wr_data_r <= '{len: item_r.ssid_length, name: in_name,
                       chan: item_r.beacon_chan, sec: item_r.security_class};
        status_r  <= ST_INSERTED;
      end
    end
    if (state_r == S_OUT) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
